>>> design/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants for the 3x3 box blur
// Pixel layout, register indexes, beat kinds and the reciprocal table that
// turns the rounded window mean into a multiply and a shift.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int FW_RESET       = 1024;
  localparam int FH_RESET       = 768;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam int TDATA_BITS  = 24;
  localparam int PIX_BITS    = 2 * TDATA_BITS;
  localparam int COL_BITS    = 10;
  localparam int SUM_BITS    = 12;
  localparam int X_BITS      = 13;
  localparam int CNT_BITS    = 4;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_BITS  = 20;
  localparam int PROD_BITS   = X_BITS + RECIP_BITS;

  // ceil(2^shift / 2n) for each window size n
  localparam int RECIP_N1 = (2**RECIP_SHIFT + 2*1 - 1) / (2*1);
  localparam int RECIP_N2 = (2**RECIP_SHIFT + 2*2 - 1) / (2*2);
  localparam int RECIP_N3 = (2**RECIP_SHIFT + 2*3 - 1) / (2*3);
  localparam int RECIP_N4 = (2**RECIP_SHIFT + 2*4 - 1) / (2*4);
  localparam int RECIP_N6 = (2**RECIP_SHIFT + 2*6 - 1) / (2*6);
  localparam int RECIP_N9 = (2**RECIP_SHIFT + 2*9 - 1) / (2*9);

  // blue in the top byte so the struct matches tdata (red lowest)
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef logic [CNT_BITS-1:0] cnt_t;

  function automatic logic [RECIP_BITS-1:0] recip_of(input cnt_t n);
    logic [RECIP_BITS-1:0] m;
    case (n)
      4'd1:    m = RECIP_BITS'(RECIP_N1);
      4'd2:    m = RECIP_BITS'(RECIP_N2);
      4'd3:    m = RECIP_BITS'(RECIP_N3);
      4'd4:    m = RECIP_BITS'(RECIP_N4);
      4'd6:    m = RECIP_BITS'(RECIP_N6);
      4'd9:    m = RECIP_BITS'(RECIP_N9);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> design/bblur_ram.sv
// ----------------------------------------------------------------------------
// bblur_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/box_blur_3x3_edge_truncated.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_truncated: streaming 3x3 box blur, RGB888
// Raster-order pixels in, per-channel rounded mean of the in-frame 3x3
// window out, one row plus one pixel behind. Drain beats flush the tail.
//
// channel  dir  handshake         payload
// in_      in   tvalid / tready   tdata = red, green, blue; tuser = mode
// out_     out  tvalid / tready   tdata = red, green, blue; tlast = frame_end
// cfg_     in   we                index, wdata (frame_width, frame_height)
//
// A beat that yields a result holds tready low through the line-buffer read,
// read-modify-write of the buffer and window, column sums, total, multiply.
// A beat with no result ends after the read and the read-modify-write;
// a drain on a one-row frame may walk two positions, and an early drain is
// accepted without leaving idle. The combined RAM word holds both rows.
// rst_n is synchronous; line buffers are not cleared (no clearing pass).
// The final stage waits while the output register is still full.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_truncated
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [TDATA_BITS-1:0]     in_tdata,   // red, green, blue
  input  logic                      in_tuser,   // mode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [TDATA_BITS-1:0]     out_tdata,  // red, green, blue
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MEM  = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_DIV  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FW_BITS-1:0] frame_width_r, frame_width_nxt;
  logic [FH_BITS-1:0] frame_height_r, frame_height_nxt;
  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [RW-1:0]     in_row_r, in_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [RW-1:0]     out_row_r, out_row_nxt;
  logic              real_r, real_nxt;
  logic              second_r, second_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              add_r, add_nxt;

  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [WW-1:0]     ic_inc, oc_inc;
  logic              row_past_end, emit, last_c, load;

  logic [PIX_BITS-1:0] ram_rdata;
  pixel_t            px_r;
  pixel_t [2:0]      new_col;
  pixel_t [2:0]      col_a_r, col_b_r;
  pixel_t [2:0]      win_r [3];
  logic              ml_r, mr_r, mt_r, mb_r, last_r;
  logic [2:0]        row_en;

  logic [COL_BITS-1:0]   colsum_c [3][3];
  logic [COL_BITS-1:0]   colsum_r [3][3];
  logic [SUM_BITS-1:0]   sum_c [3];
  logic [X_BITS-1:0]     x_c [3];
  logic [X_BITS-1:0]     x_r [3];
  logic [1:0]            ncols, nrows;
  cnt_t                  n_c;
  logic [RECIP_BITS-1:0] recip_r;
  logic [PROD_BITS-1:0]  prod_c [3];
  pixel_t                out_pix_c;
  pixel_t                out_pix_r;
  logic                  out_last_r;

  // effective frame size, out-of-range values clamped
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  bblur_ram #(
    .WIDTH(PIX_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (state_r == ST_MEM && real_r),
    .waddr(in_col_r),
    .wdata({ram_rdata[TDATA_BITS-1:0], px_r}),
    .re   (state_r == ST_RD),
    .raddr(in_col_r),
    .rdata(ram_rdata)
  );

  // ram word: older row in the upper half, recent row in the lower half
  assign new_col[0] = pixel_t'(ram_rdata[PIX_BITS-1:TDATA_BITS]);
  assign new_col[1] = pixel_t'(ram_rdata[TDATA_BITS-1:0]);
  assign new_col[2] = real_r ? px_r : pixel_t'('0);

  assign ic_inc       = WW'(in_col_r) + WW'(1);
  assign oc_inc       = WW'(out_col_r) + WW'(1);
  assign row_past_end = in_row_r >= RW'(h_eff);
  assign emit         = (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
  assign last_c       = (out_row_r + RW'(1) == RW'(h_eff)) && (oc_inc == w_eff);
  assign load         = (state_r == ST_DIV) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt        = state_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    in_col_nxt       = in_col_r;
    in_row_nxt       = in_row_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    real_nxt         = real_r;
    second_nxt       = second_r;
    add_nxt          = add_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          real_nxt   = (in_tuser != MODE_DRAIN);
          second_nxt = 1'b0;
          if (in_tuser != MODE_DRAIN) begin
            if (row_past_end) begin
              in_col_nxt  = '0;
              in_row_nxt  = '0;
              out_col_nxt = '0;
              out_row_nxt = '0;
            end
            state_nxt = ST_RD;
          end else if (row_past_end) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_MEM;
      end
      ST_MEM: begin
        if (emit && last_c) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else begin
          if (emit) begin
            if (oc_inc >= w_eff) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + RW'(1);
            end else begin
              out_col_nxt = CW'(oc_inc);
            end
          end
          if (ic_inc >= w_eff) begin
            in_col_nxt = '0;
            in_row_nxt = in_row_r + RW'(1);
          end else begin
            in_col_nxt = CW'(ic_inc);
          end
        end
        add_nxt = 1'b0;
        if (emit) begin
          state_nxt = ST_SUM;
        end else if (!real_r && !second_r) begin
          // one-row frame: drain walks one more position
          second_nxt = 1'b1;
          state_nxt  = ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        // two passes: column sums, then total and count
        add_nxt = 1'b1;
        if (add_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= FW_BITS'(FW_RESET);
      frame_height_r <= FH_BITS'(FH_RESET);
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      real_r         <= 1'b0;
      second_r       <= 1'b0;
      add_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      real_r         <= real_nxt;
      second_r       <= second_nxt;
      add_r          <= add_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // column sums over the rows that lie in the frame
  assign row_en = {mb_r, 1'b1, mt_r};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int col = 0; col < 3; col++) begin
        colsum_c[ch][col] = '0;
        for (int k = 0; k < 3; k++) begin
          if (row_en[k]) begin
            colsum_c[ch][col] = colsum_c[ch][col] + COL_BITS'(win_r[col][k][8*ch +: 8]);
          end
        end
      end
    end
  end

  // rounded mean: (2*sum + n) / (2n) as multiply by reciprocal
  always_comb begin
    ncols = 2'd1 + 2'(ml_r) + 2'(mr_r);
    nrows = 2'd1 + 2'(mt_r) + 2'(mb_r);
    n_c   = CNT_BITS'(ncols) * CNT_BITS'(nrows);
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = SUM_BITS'(ml_r ? colsum_r[ch][0] : '0) + SUM_BITS'(colsum_r[ch][1])
                + SUM_BITS'(mr_r ? colsum_r[ch][2] : '0);
      x_c[ch]   = {sum_c[ch], 1'b0} + X_BITS'(n_c);
    end
  end

  always_comb begin
    out_pix_c = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod_c[ch] = PROD_BITS'(x_r[ch]) * PROD_BITS'(recip_r);
      out_pix_c[8*ch +: 8] = prod_c[ch][RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      px_r <= pixel_t'(in_tdata);
    end
    if (state_r == ST_MEM) begin
      win_r[0] <= col_a_r;
      win_r[1] <= col_b_r;
      win_r[2] <= new_col;
      ml_r     <= (out_col_r != '0);
      mr_r     <= (in_col_r != '0);
      mt_r     <= (out_row_r != '0);
      mb_r     <= (out_row_r + RW'(1) < RW'(h_eff));
      last_r   <= last_c;
      if (in_col_r == '0) begin
        col_a_r <= '0;
      end else begin
        col_a_r <= col_b_r;
      end
      col_b_r <= new_col;
    end
    if (state_r == ST_SUM && !add_r) begin
      colsum_r <= colsum_c;
    end
    if (state_r == ST_SUM && add_r) begin
      x_r     <= x_c;
      recip_r <= recip_of(n_c);
    end
    if (load) begin
      out_pix_r  <= out_pix_c;
      out_last_r <= last_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

>>> design/bblur_checker.sv
// ----------------------------------------------------------------------------
// bblur_checker: port-level checks for the 3x3 box blur
// Output hold under stall, reset state, and the one-beat-at-a-time timing.
// ----------------------------------------------------------------------------
module bblur_checker
  import bblur_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_BITS-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_PIXEL |=> !in_tready)
    else $error("pixel beat did not occupy the block");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared right after an input beat");

endmodule

bind box_blur_3x3_edge_truncated bblur_checker u_bblur_checker (.*);

>>> tb/sv/tb_box_blur_3x3_edge_truncated.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_truncated: self-checking bench for the 3x3 box blur
// Streams raster-order frames of many sizes, with drain beats, early drains and
// frames cut short by new pixels. A built-in window model predicts every
// blurred pixel, and the monitor compares each output beat against it field by
// field. Both sides stall in random bursts, and one long receiver hold backs
// up the input.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_truncated;
  import bblur_pkg::*;

  typedef struct packed {
    logic   mode;
    pixel_t pix;
  } blur_beat_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } blur_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [TDATA_BITS-1:0]     in_tdata = '0;
  logic                      in_tuser = MODE_PIXEL;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [TDATA_BITS-1:0]     out_tdata;
  logic                      out_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  box_blur_3x3_edge_truncated dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // red, green, blue
    .in_tuser   (in_tuser),   // mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // red, green, blue
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // window model state
  pixel_t       older_row  [MAX_WIDTH_DEF];
  pixel_t       recent_row [MAX_WIDTH_DEF];
  pixel_t       blur_win   [9];
  int unsigned  in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  logic [FW_BITS-1:0] cur_width  = FW_BITS'(FW_RESET);
  logic [FH_BITS-1:0] cur_height = FH_BITS'(FH_RESET);

  blur_result_t blurred_expect [$];
  blur_beat_t   pixel_feed [$];
  int unsigned  beats_queued = 0, beats_taken = 0, random_beats = 0;
  int unsigned  err_count = 0;
  int unsigned  send_gap = 0, recv_gap = 0;
  bit           idle_en = 1'b1;
  bit           hold_armed = 1'b0;
  logic         holding = 1'b0;

  initial begin
    for (int i = 0; i < 9; i++) blur_win[i] = '0;
  end

  function automatic void blur_restart();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // result for (out_row, out_col); window column cc holds its center
  function automatic bit blur_emit(int cc, int unsigned w, int unsigned h);
    int unsigned  r, c, n, sum_r, sum_g, sum_b;
    int           col;
    pixel_t       px;
    blur_result_t res;
    r = out_row;
    c = out_col;
    n = 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int dc = -1; dc <= 1; dc++) begin
      col = cc + dc;
      if (col < 0 || col > 2) continue;
      if (dc < 0 && c == 0) continue;
      if (dc > 0 && c + 1 >= w) continue;
      for (int dr = -1; dr <= 1; dr++) begin
        if (dr < 0 && r == 0) continue;
        if (dr > 0 && r + 1 >= h) continue;
        px = blur_win[col * 3 + dr + 1];
        sum_r += px.red;
        sum_g += px.green;
        sum_b += px.blue;
        n++;
      end
    end
    if (n == 0) n = 1;
    res.red       = 8'((2 * sum_r + n) / (2 * n));
    res.green     = 8'((2 * sum_g + n) / (2 * n));
    res.blue      = 8'((2 * sum_b + n) / (2 * n));
    res.frame_end = (r == h - 1) && (c == w - 1);
    blurred_expect.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      blur_restart();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one real or virtual raster position; returns the number of results
  function automatic int blur_walk(pixel_t px, bit carried, int unsigned w, int unsigned h);
    int unsigned ic, ir;
    bit          emitting, done;
    pixel_t      top, mid;
    int          got;
    ic = in_col;
    ir = in_row;
    emitting = (ir >= 2) || (ir == 1 && ic >= 1);
    done = 1'b0;
    got = 0;
    top = older_row[ic];
    mid = recent_row[ic];
    if (carried) begin
      older_row[ic]  = mid;
      recent_row[ic] = px;
    end
    if (ic == 0) begin
      if (emitting) begin
        done = blur_emit(2, w, h);
        got = 1;
      end
      for (int k = 0; k < 6; k++) blur_win[k] = '0;
    end else begin
      for (int k = 0; k < 6; k++) blur_win[k] = blur_win[k + 3];
    end
    blur_win[6] = top;
    blur_win[7] = mid;
    blur_win[8] = carried ? px : '0;
    if (ic != 0 && emitting) begin
      done = blur_emit(1, w, h);
      got = 1;
    end
    if (!done) begin
      in_col = ic + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = ir + 1;
      end
    end
    return got;
  endfunction

  function automatic void blur_predict(logic mode, pixel_t px);
    int unsigned w, h;
    w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : cur_width);
    h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : cur_height);
    if (mode == MODE_PIXEL) begin
      if (in_row >= h) blur_restart();
      void'(blur_walk(px, 1'b1, w, h));
    end else if (in_row >= h) begin
      // drain walks up to two virtual positions for one result
      if (blur_walk('0, 1'b0, w, h) == 0) void'(blur_walk('0, 1'b0, w, h));
    end
  endfunction

  // input driver
  always @(posedge clk) begin : beat_driver
    blur_beat_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        blur_predict(in_tuser, pixel_t'(in_tdata));
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          if (idle_en && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 15);
            in_tvalid <= 1'b0;
          end else begin
            nxt = pixel_feed.pop_front();
            in_tvalid <= 1'b1;
            in_tdata  <= nxt.pix;
            in_tuser  <= nxt.mode;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(string field, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      err_count++;
    end
  endfunction

  // output monitor and receiver stalls
  always @(posedge clk) begin : result_monitor
    pixel_t       seen;
    blur_result_t want;
    if (out_tvalid && out_tready) begin
      seen = out_tdata;
      if (blurred_expect.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        err_count++;
      end else begin
        want = blurred_expect.pop_front();
        compare_field("red", want.red, seen.red);
        compare_field("green", want.green, seen.green);
        compare_field("blue", want.blue, seen.blue);
        compare_field("frame_end", want.frame_end, out_tlast);
      end
    end
    if (!rst_n || holding) begin
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // long receiver hold so the block backs up and stalls its input
  initial begin : receiver_hold
    wait (hold_armed);
    @(posedge clk);
    holding <= 1'b1;
    repeat (600) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void queue_beat(logic mode, pixel_t pix);
    blur_beat_t b;
    b.mode = mode;
    b.pix  = pix;
    pixel_feed.push_back(b);
    beats_queued++;
  endfunction

  function automatic pixel_t rand_pix(bit extremes);
    pixel_t p;
    if (extremes) begin
      p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      p.red   = 8'($urandom_range(0, 255));
      p.green = 8'($urandom_range(0, 255));
      p.blue  = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic wait_idle();
    while (beats_taken != beats_queued || blurred_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cur_width = value[FW_BITS-1:0];
    else cur_height = value[FH_BITS-1:0];
    blur_restart();
  endtask

  task automatic set_frame(logic [CFG_DATA_BITS-1:0] raw_w, logic [CFG_DATA_BITS-1:0] raw_h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, raw_w);
    write_reg(REG_FRAME_HEIGHT, raw_h);
  endtask

  // full frame, then drains; sometimes an early drain, sometimes cut short
  task automatic queue_frame(int unsigned w, int unsigned h);
    int unsigned total, early_at, drains;
    bit          extremes;
    total = w * h;
    extremes = ($urandom_range(0, 5) == 0);
    early_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == early_at) queue_beat(MODE_DRAIN, rand_pix(1'b0));
      queue_beat(MODE_PIXEL, rand_pix(extremes));
    end
    drains = w + 1 + $urandom_range(0, 1);
    if ($urandom_range(0, 7) == 0) drains = $urandom_range(0, w);
    repeat (drains) queue_beat(MODE_DRAIN, rand_pix(1'b0));
    random_beats += total + drains;
  endtask

  initial begin : stimulus
    int unsigned fw, fh;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 3x2 frame: extremes, early drain, drains, drain with nothing pending
    set_frame(3, 2);
    queue_beat(MODE_PIXEL, 24'hFFFFFF);
    queue_beat(MODE_PIXEL, 24'h000000);
    queue_beat(MODE_DRAIN, 24'h5A5AA5);
    queue_beat(MODE_PIXEL, 24'h8000FF);
    queue_beat(MODE_PIXEL, 24'h7FFE01);
    queue_beat(MODE_PIXEL, 24'hFFFFFF);
    queue_beat(MODE_PIXEL, 24'h000000);
    repeat (5) queue_beat(MODE_DRAIN, 24'hA5A55A);
    // second frame, one drain, then a pixel that drops the rest
    queue_beat(MODE_PIXEL, 24'h010203);
    queue_beat(MODE_PIXEL, 24'hFF00FF);
    queue_beat(MODE_PIXEL, 24'h00FF00);
    queue_beat(MODE_PIXEL, 24'hFEFDFC);
    queue_beat(MODE_PIXEL, 24'h808080);
    queue_beat(MODE_PIXEL, 24'h7F7F7F);
    queue_beat(MODE_DRAIN, 24'hFFFFFF);
    queue_beat(MODE_PIXEL, 24'hFFFFFF);

    // widest rows, tallest frame, abandoned after the first results
    set_frame(1024, 4096);
    repeat (MAX_WIDTH_DEF + 30) queue_beat(MODE_PIXEL, rand_pix(1'b0));

    // out-of-range sizes clamp to the maximum
    set_frame(13'h07FF, 13'h1FFF);
    repeat (20) queue_beat(MODE_PIXEL, rand_pix(1'b0));

    // zero sizes act as a single pixel
    set_frame(0, 0);
    repeat (6) begin
      queue_beat(MODE_PIXEL, rand_pix(1'b0));
      queue_beat(MODE_DRAIN, rand_pix(1'b0));
    end

    while (random_beats < 200) begin
      fw = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      fh = $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) fw = 0;
      if ($urandom_range(0, 15) == 0) fh = 0;
      set_frame(CFG_DATA_BITS'(fw), CFG_DATA_BITS'(fh));
      idle_en = ($urandom_range(0, 3) != 0);
      if (fw == 0) fw = 1;
      if (fh == 0) fh = 1;
      repeat ($urandom_range(1, 3)) queue_frame(fw, fh);
    end

    // backpressure: receiver holds off while the sender keeps offering
    set_frame(16, 8);
    idle_en = 1'b0;
    hold_armed = 1'b1;
    queue_frame(16, 8);

    set_frame(5, 4);
    repeat (3) queue_frame(5, 4);

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
